>>> rtl/hbsd_pkg.sv
// Shared types and constants for the HDLC bit stuffer and destuffer.
package hbsd_pkg;

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;
  localparam logic [2:0] RUN_LIMIT    = 3'd5;

  localparam logic MODE_STUFF   = 1'b0;
  localparam logic MODE_DESTUFF = 1'b1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int TDATA_W    = 8;
  localparam int OUT_TUSER_W = 4;

  typedef struct packed {
    logic open_flag;
    logic bit_val;
    logic bit_valid;
    logic bit_done;
    logic bit_err;
    logic stuff_zero;
    logic close_flag;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/hdlc_bit_stuffer_destuffer_core.sv
// Top level of the HDLC bit stuffer and destuffer.
// One serial bit enters per request; mode 0 stuffs payload bits and wraps frames
// in 01111110 flags, mode 1 drops the zero after five ones and reports a sixth one
// as an error. The output sequencer gives one result per cycle while out_ready holds, so a
// bit that yields a single result passes at one per cycle. Extra results come from the
// opening flag at a frame start, a stuffed zero and the closing flag at a frame end;
// a 4-entry command queue between the classifier and the sequencer absorbs these,
// and the input stalls only when that queue is full. A destuffed zero that ends no
// frame produces no result. Write mode only while no request is in flight.
module hdlc_bit_stuffer_destuffer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [hbsd_pkg::TDATA_W-1:0]        in_tdata,   // [0] data_bit, rest zero
  input  logic                                in_tuser,   // [0] frame_start
  input  logic                                in_tlast,   // frame_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hbsd_pkg::TDATA_W-1:0]        out_tdata,  // [0] out_bit, rest zero
  // [0] bit_valid, [1] is_flag, [2] run_last, [3] stuff_error
  output logic [hbsd_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast   // frame_done
);

  hbsd_pkg::q_stat_t q_stat;
  hbsd_pkg::cmd_t    push_cmd;
  hbsd_pkg::cmd_t    head_cmd;
  logic              push;
  logic              pop;
  logic              out_bit;
  logic              bit_valid;
  logic              is_flag;
  logic              frame_done;
  logic              run_last;
  logic              stuff_error;

  hbsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_bit    (in_tdata[0]),
    .frame_start (in_tuser),
    .frame_end   (in_tlast),
    .q_stat      (q_stat),
    .push        (push),
    .cmd         (push_cmd)
  );

  hbsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  hbsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_cmd    (head_cmd),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_bit     (out_bit),
    .bit_valid   (bit_valid),
    .is_flag     (is_flag),
    .frame_done  (frame_done),
    .run_last    (run_last),
    .stuff_error (stuff_error)
  );

  assign out_tdata = {{(hbsd_pkg::TDATA_W-1){1'b0}}, out_bit};
  assign out_tuser = {stuff_error, run_last, is_flag, bit_valid};
  assign out_tlast = frame_done;

  a_err_no_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> !out_tuser[0] && !out_tuser[1])
    else $error("error marker carries a bit");

  a_flag_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] && out_tlast |-> out_tuser[2])
    else $error("closing flag does not end the run");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_flag_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && !out_tuser[3])
    else $error("flag bit without valid data");

endmodule

>>> rtl/hbsd_front.sv
// Front end: accepts bits, tracks the ones run and classifies each request.
module hbsd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              data_bit,
  input  logic              frame_start,
  input  logic              frame_end,
  input  hbsd_pkg::q_stat_t q_stat,
  output logic              push,
  output hbsd_pkg::cmd_t    cmd
);

  logic       mode_r;
  logic [2:0] ones_run_r;
  logic [2:0] ones_run_nxt;
  logic [2:0] run0;
  logic [2:0] run1;
  logic       accept;
  logic       keep;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && keep;

  always_comb begin
    run0         = frame_start ? 3'd0 : ones_run_r;
    run1         = 3'd0;
    keep         = 1'b1;
    cmd          = '0;
    ones_run_nxt = run0;
    if (mode_r == hbsd_pkg::MODE_STUFF) begin
      cmd.open_flag  = frame_start;
      cmd.bit_val    = data_bit;
      cmd.bit_valid  = 1'b1;
      cmd.close_flag = frame_end;
      if (data_bit) begin
        run1 = (run0 < hbsd_pkg::RUN_LIMIT) ? run0 + 3'd1 : run0;
      end
      cmd.stuff_zero = (run1 >= hbsd_pkg::RUN_LIMIT);
      ones_run_nxt   = (cmd.stuff_zero || frame_end) ? 3'd0 : run1;
    end else begin
      cmd.bit_done = frame_end;
      if (run0 >= hbsd_pkg::RUN_LIMIT) begin
        keep         = data_bit || frame_end;
        cmd.bit_err  = data_bit;
        ones_run_nxt = 3'd0;
      end else begin
        cmd.bit_val   = data_bit;
        cmd.bit_valid = 1'b1;
        ones_run_nxt  = data_bit ? run0 + 3'd1 : 3'd0;
      end
      if (frame_end) begin
        ones_run_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= hbsd_pkg::MODE_STUFF;
      ones_run_r <= 3'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (accept) begin
        ones_run_r <= ones_run_nxt;
      end
    end
  end

endmodule

>>> rtl/hbsd_queue.sv
// Short command queue between the front end and the output sequencer.
module hbsd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hbsd_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output hbsd_pkg::cmd_t    head_cmd,
  output hbsd_pkg::q_stat_t q_stat
);

  hbsd_pkg::cmd_t              entry_r [hbsd_pkg::Q_DEPTH];
  logic [hbsd_pkg::Q_AW-1:0]   wr_ptr_r;
  logic [hbsd_pkg::Q_AW-1:0]   rd_ptr_r;
  logic [hbsd_pkg::Q_CW-1:0]   count_r;
  logic                        do_push;
  logic                        do_pop;

  assign q_stat.full  = (count_r == hbsd_pkg::Q_CW'(hbsd_pkg::Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/hbsd_back.sv
// Output sequencer: expands each command into flag, data and stuffed bits.
module hbsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hbsd_pkg::cmd_t    head_cmd,
  input  hbsd_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_bit,
  output logic              bit_valid,
  output logic              is_flag,
  output logic              frame_done,
  output logic              run_last,
  output logic              stuff_error
);

  localparam logic [1:0] PH_OPEN  = 2'd0;
  localparam logic [1:0] PH_MAIN  = 2'd1;
  localparam logic [1:0] PH_STUFF = 2'd2;
  localparam logic [1:0] PH_CLOSE = 2'd3;

  logic           active_r;
  logic [1:0]     phase_r;
  logic [1:0]     phase_nxt;
  logic [2:0]     idx_r;
  logic [2:0]     idx_nxt;
  hbsd_pkg::cmd_t cmd_r;
  logic           flag_bit;
  logic           step;
  logic           load;

  assign flag_bit  = hbsd_pkg::FLAG_PATTERN[3'd7 - idx_r];
  assign out_valid = active_r;
  assign step      = active_r && out_ready;
  assign load      = (!active_r || (step && run_last)) && !q_stat.empty;
  assign pop       = load;

  always_comb begin
    out_bit     = 1'b0;
    bit_valid   = 1'b1;
    is_flag     = 1'b0;
    frame_done  = 1'b0;
    run_last    = 1'b0;
    stuff_error = 1'b0;
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    unique case (phase_r)
      PH_OPEN: begin
        out_bit = flag_bit;
        is_flag = 1'b1;
        if (idx_r == 3'd7) begin
          phase_nxt = PH_MAIN;
          idx_nxt   = 3'd0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_MAIN: begin
        out_bit     = cmd_r.bit_val;
        bit_valid   = cmd_r.bit_valid;
        frame_done  = cmd_r.bit_done;
        stuff_error = cmd_r.bit_err;
        run_last    = !cmd_r.stuff_zero && !cmd_r.close_flag;
        phase_nxt   = cmd_r.stuff_zero ? PH_STUFF : PH_CLOSE;
        idx_nxt     = 3'd0;
      end
      PH_STUFF: begin
        run_last  = !cmd_r.close_flag;
        phase_nxt = PH_CLOSE;
        idx_nxt   = 3'd0;
      end
      PH_CLOSE: begin
        out_bit    = flag_bit;
        is_flag    = 1'b1;
        frame_done = (idx_r == 3'd7);
        run_last   = (idx_r == 3'd7);
        idx_nxt    = idx_r + 3'd1;
      end
      default: begin
        phase_nxt = PH_MAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= head_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= PH_MAIN;
      idx_r    <= 3'd0;
    end else if (load) begin
      active_r <= 1'b1;
      phase_r  <= head_cmd.open_flag ? PH_OPEN : PH_MAIN;
      idx_r    <= 3'd0;
    end else if (step) begin
      if (run_last) begin
        active_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
